// ===== sv/ssr_pkg.sv =====
// Shared types and constants for the selection set with swap-remove.
// Used by selection_set_swap_remove and its testbench; no dependencies.
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int REQ_W   = 2;
    localparam int ID_FW   = 10;
    localparam int SLOT_FW = 6;
    localparam int CNT_FW  = 7;
    localparam int REV_W   = 32;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SELECT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DESELECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ     = 2'd3;

    // status codes
    localparam logic [1:0] STAT_CHANGED  = 2'd0;
    localparam logic [1:0] STAT_NOCHANGE = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    typedef struct packed {
        logic [SLOT_FW-1:0] slot_index;
        logic [ID_FW-1:0]   entity_id;
        logic [REQ_W-1:0]   req_type;
    } req_t;

    typedef struct packed {
        logic [REV_W-1:0]   revision_out;
        logic [ID_FW-1:0]   moved_id;
        logic               moved_valid;
        logic [ID_FW-1:0]   read_id;
        logic [SLOT_FW-1:0] slot_used;
        logic [CNT_FW-1:0]  member_count;
        logic [1:0]         status;
    } res_t;

endpackage

// ===== sv/ssr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    bit   [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/selection_set_swap_remove.sv =====
// Selection set with swap-remove: dense member RAM plus slot-per-ID index RAM.
// Depends on ssr_pkg and ssr_ram.
`timescale 1ns / 1ps
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  s_      | in  | s_tvalid/tready  | s_tdata: req_type, entity_id, slot_index
//  m_      | out | m_tvalid/tready  | m_tdata: status .. revision_out
//
// Each request passes through accept (index and last-member reads issued),
// lookup (freed-slot read issued from the index) and check (member test and
// write-back). The member read needs the slot returned by the index read, so
// the two RAM reads sit in series ahead of the check.
// Reset clears state, count, revision and output valid; the RAMs are not cleared.
// A finished result waits in the output register; the next request is taken
// meanwhile and holds in the check stage until that register frees.

module selection_set_swap_remove #(
    parameter int ID_SPACE     = 1024,
    parameter int SET_CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] req_type, [11:2] entity_id, [17:12] slot_index, [23:18] zero
    input  logic [ssr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [8:2] member_count, [14:9] slot_used, [24:15] read_id,
    // [25] moved_valid, [35:26] moved_id, [67:36] revision_out, [71:68] zero
    output logic [ssr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(SET_CAPACITY);
    localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
    localparam int ID_AW  = $clog2(ID_SPACE);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOOK  = 3'b010,
        ST_CHECK = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    ssr_pkg::req_t               req_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ssr_pkg::REV_W-1:0]   rev_reg, rev_next;
    logic [SLOT_W-1:0]           s_reg;
    logic [ssr_pkg::ID_FW-1:0]   last_id_reg;
    ssr_pkg::res_t               res_reg, res_next;
    logic                        m_valid_reg;

    ssr_pkg::req_t               in_req;
    logic                        s_fire;
    logic                        out_free;
    logic                        done;

    logic                        dense_we;
    logic [SLOT_W-1:0]           dense_waddr, dense_raddr;
    logic [ssr_pkg::ID_FW-1:0]   dense_wdata, dense_rdata;
    logic                        slot_we;
    logic [ID_AW-1:0]            slot_waddr;
    logic [SLOT_W-1:0]           slot_wdata, slot_rdata;

    logic                        id_ok, member, last_ok;
    logic [CNT_W-1:0]            last_cnt;

    assign in_req   = ssr_pkg::req_t'(s_tdata[$bits(ssr_pkg::req_t)-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign done     = (state_reg == ST_CHECK) && out_free;

    ssr_ram #(.WIDTH(ssr_pkg::ID_FW), .DEPTH(SET_CAPACITY)) u_dense (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    ssr_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_slot (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (ID_AW'(in_req.entity_id)),
        .rdata (slot_rdata)
    );

    // dense read: requested slot or last member at accept, freed slot after
    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req.req_type == ssr_pkg::REQ_READ) begin
                    dense_raddr = SLOT_W'(in_req.slot_index);
                end else begin
                    dense_raddr = SLOT_W'(count_reg - CNT_W'(1));
                end
            end
            ST_LOOK:  dense_raddr = slot_rdata;
            ST_CHECK: dense_raddr = s_reg;
            default:  dense_raddr = s_reg;
        endcase
    end

    assign last_cnt = count_reg - CNT_W'(1);
    assign id_ok    = 32'(req_reg.entity_id) < ID_SPACE;
    assign member   = id_ok && (32'(s_reg) < 32'(count_reg))
                      && (dense_rdata == req_reg.entity_id);
    assign last_ok  = 32'(last_id_reg) < ID_SPACE;

    always_comb begin
        res_next              = '0;
        res_next.status       = ssr_pkg::STAT_NOCHANGE;
        count_next            = count_reg;
        rev_next              = rev_reg;
        dense_we              = 1'b0;
        dense_waddr           = s_reg;
        dense_wdata           = last_id_reg;
        slot_we               = 1'b0;
        slot_waddr            = ID_AW'(last_id_reg);
        slot_wdata            = s_reg;

        case (req_reg.req_type)
            ssr_pkg::REQ_SELECT: begin
                if (id_ok && !member) begin
                    if (32'(count_reg) >= SET_CAPACITY) begin
                        res_next.status = ssr_pkg::STAT_FULL;
                    end else begin
                        dense_we           = done;
                        dense_waddr        = SLOT_W'(count_reg);
                        dense_wdata        = req_reg.entity_id;
                        slot_we            = done;
                        slot_waddr         = ID_AW'(req_reg.entity_id);
                        slot_wdata         = SLOT_W'(count_reg);
                        res_next.slot_used = ssr_pkg::SLOT_FW'(count_reg);
                        count_next         = count_reg + CNT_W'(1);
                        rev_next           = rev_reg + 1'b1;
                        res_next.status    = ssr_pkg::STAT_CHANGED;
                    end
                end
            end
            ssr_pkg::REQ_DESELECT: begin
                if (member) begin
                    dense_we = done;
                    // swap the last member into the freed slot
                    if (CNT_W'(s_reg) != last_cnt) begin
                        slot_we              = done && last_ok;
                        res_next.moved_valid = 1'b1;
                        res_next.moved_id    = last_id_reg;
                    end
                    res_next.slot_used = ssr_pkg::SLOT_FW'(s_reg);
                    count_next         = last_cnt;
                    rev_next           = rev_reg + 1'b1;
                    res_next.status    = ssr_pkg::STAT_CHANGED;
                end
            end
            ssr_pkg::REQ_CLEAR: begin
                if (count_reg != '0) begin
                    count_next      = '0;
                    rev_next        = rev_reg + 1'b1;
                    res_next.status = ssr_pkg::STAT_CHANGED;
                end
            end
            default: begin
                res_next.slot_used = req_reg.slot_index;
                if ((32'(req_reg.slot_index) < 32'(count_reg))
                        && (32'(req_reg.slot_index) < SET_CAPACITY)) begin
                    res_next.read_id = last_id_reg;
                end else begin
                    res_next.status = ssr_pkg::STAT_RANGE;
                end
            end
        endcase

        res_next.member_count = ssr_pkg::CNT_FW'(count_next);
        res_next.revision_out = rev_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_CHECK;
            ST_CHECK: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rev_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (done) begin
                count_reg   <= count_next;
                rev_reg     <= rev_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= in_req;
        end
        // index and last member (or read data) land during lookup
        if (state_reg == ST_LOOK) begin
            s_reg       <= slot_rdata;
            last_id_reg <= dense_rdata;
        end
        if (done) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(ssr_pkg::M_TDATA_W - $bits(ssr_pkg::res_t))'(0), res_reg};

endmodule

// ===== sim/tb_selection_set_swap_remove.sv =====
// Self-checking bench for selection_set_swap_remove: directed and random requests, predicted
// member set and index, field-wise result check. Depends on ssr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_selection_set_swap_remove;

    localparam int SET_CAP      = 64;
    localparam int ID_COUNT     = 1024;
    localparam int N_ITEMS      = 1650;
    localparam int PHASE_LEN    = 150;
    localparam int HOLD_AT      = 640;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int WIN_SPAN     = 80;
    localparam int REQ_BITS     = $bits(ssr_pkg::req_t);
    localparam int RES_BITS     = $bits(ssr_pkg::res_t);

    typedef struct {
        ssr_pkg::req_t rq;
        bit            drain_first;   // hold off until every pending result has come back
    } pending_req_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ssr_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ssr_pkg::M_TDATA_W-1:0] m_tdata;

    // predicted state of the set
    logic [ssr_pkg::ID_FW-1:0]   set_members [SET_CAP] = '{default: '0};
    logic [ssr_pkg::SLOT_FW-1:0] slot_of_member [ID_COUNT] = '{default: '0};
    logic [ssr_pkg::CNT_FW-1:0]  member_cnt = '0;
    logic [ssr_pkg::REV_W-1:0]   rev_cnt = '0;

    pending_req_t  req_queue [$];
    ssr_pkg::res_t expected_results [$];
    int            n_accepted = 0;
    int            n_errors = 0;
    bit            s_accepted = 1'b0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    int unsigned   idle_pct [4] = '{0, 70, 0, 26};
    int unsigned   stall_pct [4] = '{0, 0, 70, 26};

    selection_set_swap_remove u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_selected(logic [ssr_pkg::ID_FW-1:0] id);
        logic [ssr_pkg::SLOT_FW-1:0] s;
        s = slot_of_member[id];
        return ({1'b0, s} < member_cnt) && (set_members[s] == id);
    endfunction

    function automatic ssr_pkg::res_t apply_request(ssr_pkg::req_t rq);
        ssr_pkg::res_t               r;
        logic [ssr_pkg::CNT_FW-1:0]  last;
        logic [ssr_pkg::ID_FW-1:0]   last_id;
        logic [ssr_pkg::SLOT_FW-1:0] idx;
        r = '0;
        r.status = ssr_pkg::STAT_NOCHANGE;
        case (rq.req_type)
            ssr_pkg::REQ_SELECT: begin
                if (!is_selected(rq.entity_id)) begin
                    if (member_cnt >= SET_CAP) begin
                        r.status = ssr_pkg::STAT_FULL;
                    end else begin
                        set_members[member_cnt[ssr_pkg::SLOT_FW-1:0]] = rq.entity_id;
                        slot_of_member[rq.entity_id] = member_cnt[ssr_pkg::SLOT_FW-1:0];
                        r.slot_used = member_cnt[ssr_pkg::SLOT_FW-1:0];
                        member_cnt = member_cnt + 1'b1;
                        rev_cnt = rev_cnt + 1'b1;
                        r.status = ssr_pkg::STAT_CHANGED;
                    end
                end
            end
            ssr_pkg::REQ_DESELECT: begin
                if (is_selected(rq.entity_id)) begin
                    idx = slot_of_member[rq.entity_id];
                    last = member_cnt - 1'b1;
                    last_id = set_members[last[ssr_pkg::SLOT_FW-1:0]];
                    set_members[idx] = last_id;
                    member_cnt = last;
                    // swap-remove: the tail member fills the hole unless it was the hole
                    if ({1'b0, idx} != last) begin
                        slot_of_member[last_id] = idx;
                        r.moved_valid = 1'b1;
                        r.moved_id = last_id;
                    end
                    r.slot_used = idx;
                    rev_cnt = rev_cnt + 1'b1;
                    r.status = ssr_pkg::STAT_CHANGED;
                end
            end
            ssr_pkg::REQ_CLEAR: begin
                if (member_cnt != 0) begin
                    member_cnt = '0;
                    rev_cnt = rev_cnt + 1'b1;
                    r.status = ssr_pkg::STAT_CHANGED;
                end
            end
            default: begin
                r.slot_used = rq.slot_index;
                if ({1'b0, rq.slot_index} < member_cnt)
                    r.read_id = set_members[rq.slot_index];
                else
                    r.status = ssr_pkg::STAT_RANGE;
            end
        endcase
        r.member_count = member_cnt;
        r.revision_out = rev_cnt;
        return r;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            n_errors++;
        end
    endtask

    task automatic check_result(ssr_pkg::res_t got);
        ssr_pkg::res_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            n_errors++;
        end else begin
            want = expected_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("member_count", want.member_count, got.member_count);
            check_field("slot_used", want.slot_used, got.slot_used);
            check_field("read_id", want.read_id, got.read_id);
            check_field("moved_valid", want.moved_valid, got.moved_valid);
            check_field("moved_id", want.moved_id, got.moved_id);
            check_field("revision_out", want.revision_out, got.revision_out);
        end
    endtask

    // both transfer sides sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_result(ssr_pkg::res_t'(m_tdata[RES_BITS-1:0]));
            if (s_tvalid && s_tready) begin
                expected_results = {expected_results,
                                    apply_request(ssr_pkg::req_t'(s_tdata[REQ_BITS-1:0]))};
                n_accepted++;
            end
        end
        s_accepted <= aresetn && s_tvalid && s_tready;
    end

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_accepted) begin
            s_tvalid <= 1'b1;
        end else if (req_queue.size() == 0
                     || (req_queue[0].drain_first && expected_results.size() != 0)
                     || $urandom_range(0, 99) < idle_pct[(n_accepted / PHASE_LEN) % 4]) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tdata <= ssr_pkg::S_TDATA_W'(req_queue[0].rq);
            req_queue.delete(0);
            s_tvalid <= 1'b1;
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct[(n_accepted / PHASE_LEN) % 4]);
        end
    end

    task automatic add_req(logic [ssr_pkg::REQ_W-1:0] kind, int id, int slot, bit drain);
        pending_req_t p;
        p.rq.req_type = kind;
        p.rq.entity_id = ssr_pkg::ID_FW'(id);
        p.rq.slot_index = ssr_pkg::SLOT_FW'(slot);
        p.drain_first = drain;
        req_queue = {req_queue, p};
    endtask

    function automatic int window_id(int base);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, ID_COUNT - 1);
        return base + $urandom_range(0, WIN_SPAN - 1);
    endfunction

    initial begin
        int win_base;
        int mode;
        int len;
        int pick;
        bit drain;

        // empty set, basic ops, all-ones/zeros ids, swap-remove with and without move
        add_req(ssr_pkg::REQ_READ, 0, 0, 0);
        add_req(ssr_pkg::REQ_CLEAR, 0, 0, 0);
        add_req(ssr_pkg::REQ_DESELECT, 5, 63, 0);
        add_req(ssr_pkg::REQ_SELECT, 0, 63, 0);
        add_req(ssr_pkg::REQ_SELECT, 1023, 0, 0);
        add_req(ssr_pkg::REQ_SELECT, 0, 0, 0);
        add_req(ssr_pkg::REQ_SELECT, 682, 42, 0);
        add_req(ssr_pkg::REQ_SELECT, 341, 21, 0);
        add_req(ssr_pkg::REQ_READ, 1023, 0, 0);
        add_req(ssr_pkg::REQ_READ, 0, 3, 0);
        add_req(ssr_pkg::REQ_READ, 0, 4, 0);
        add_req(ssr_pkg::REQ_READ, 0, 63, 0);
        add_req(ssr_pkg::REQ_DESELECT, 0, 0, 0);
        add_req(ssr_pkg::REQ_READ, 0, 0, 0);
        add_req(ssr_pkg::REQ_DESELECT, 341, 0, 0);
        add_req(ssr_pkg::REQ_DESELECT, 1023, 0, 0);
        add_req(ssr_pkg::REQ_DESELECT, 1023, 0, 0);
        add_req(ssr_pkg::REQ_CLEAR, 1023, 63, 0);
        add_req(ssr_pkg::REQ_SELECT, 1023, 0, 0);
        add_req(ssr_pkg::REQ_DESELECT, 682, 0, 0);
        add_req(ssr_pkg::REQ_DESELECT, 1023, 0, 0);
        // fill to capacity, then one more, a member when full, a read of the top slot
        for (int i = 0; i <= SET_CAP; i++)
            add_req(ssr_pkg::REQ_SELECT, 100 + i, $urandom_range(0, 63), i == 0);
        add_req(ssr_pkg::REQ_SELECT, 100, 0, 0);
        add_req(ssr_pkg::REQ_READ, 0, 63, 0);
        add_req(ssr_pkg::REQ_DESELECT, 100, 0, 0);
        add_req(ssr_pkg::REQ_CLEAR, 0, 0, 0);

        win_base = $urandom_range(0, ID_COUNT - WIN_SPAN);
        while (req_queue.size() < N_ITEMS) begin
            mode = $urandom_range(0, 9);
            len = $urandom_range(10, 60);
            drain = ($urandom_range(0, 7) == 0);
            case (mode)
                0, 1: begin
                    // grow toward a full set
                    len = $urandom_range(40, 150);
                    for (int i = 0; i < len; i++)
                        add_req(ssr_pkg::REQ_SELECT, window_id(win_base),
                                $urandom_range(0, 63), drain && i == 0);
                end
                2, 3, 4: begin
                    for (int i = 0; i < len; i++) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 38)
                            add_req(ssr_pkg::REQ_SELECT, window_id(win_base),
                                    $urandom_range(0, 63), drain && i == 0);
                        else if (pick < 76)
                            add_req(ssr_pkg::REQ_DESELECT, window_id(win_base),
                                    $urandom_range(0, 63), drain && i == 0);
                        else if (pick < 98)
                            add_req(ssr_pkg::REQ_READ, $urandom_range(0, 1023),
                                    $urandom_range(0, 63), drain && i == 0);
                        else
                            add_req(ssr_pkg::REQ_CLEAR, $urandom_range(0, 1023),
                                    $urandom_range(0, 63), drain && i == 0);
                    end
                end
                5, 6: begin
                    // shrink, mostly swap-removes
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 4) != 0)
                            add_req(ssr_pkg::REQ_DESELECT, window_id(win_base),
                                    $urandom_range(0, 63), drain && i == 0);
                        else
                            add_req(ssr_pkg::REQ_READ, $urandom_range(0, 1023),
                                    $urandom_range(0, 20), drain && i == 0);
                    end
                end
                7: begin
                    for (int i = 0; i < len; i++)
                        add_req(ssr_pkg::REQ_READ, $urandom_range(0, 1023),
                                $urandom_range(0, 1) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 20),
                                drain && i == 0);
                end
                8: begin
                    add_req(ssr_pkg::REQ_CLEAR, $urandom_range(0, 1023),
                            $urandom_range(0, 63), drain);
                    win_base = $urandom_range(0, ID_COUNT - WIN_SPAN);
                end
                default: begin
                    // unstructured requests over the whole field ranges
                    for (int i = 0; i < len; i++)
                        add_req(ssr_pkg::REQ_W'($urandom_range(0, 3)), $urandom_range(0, 1023),
                                $urandom_range(0, 63), drain && i == 0);
                end
            endcase
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (req_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_errors == 0 && expected_results.size() == 0)
            $display("PASS selection_set_swap_remove");
        else
            $display("FAIL selection_set_swap_remove");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("FAIL selection_set_swap_remove");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ssr_pkg.sv
sv/ssr_ram.sv
sv/selection_set_swap_remove.sv
sim/tb_selection_set_swap_remove.sv
